// ===== hw/rtl/rsd_pkg.sv =====
// ---------------------------------------------------------------------------
// rsd_pkg: shared types and constants of the radial stick deadzone
// Field widths, register indexes, reset values and the types that pass
// between the front end, the job queue and the compute back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsd_pkg;

   // full scale of the stick, a power of two
   localparam int FS_LOG2    = 15;
   localparam int FULL_SCALE = 1 << FS_LOG2;

   // field widths
   localparam int AXIS_W  = 16;
   localparam int OUT_W   = 17;
   localparam int ZONE_W  = 14;
   localparam int CODE_W  = 6;
   localparam int CSR_A_W = 2;

   // job queue depth between front and back (2 or more)
   localparam int QUEUE_DEPTH = 2;

   // input commands
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_SYNC   = 1'b1;

   // axis selectors
   localparam logic AXIS_X = 1'b0;
   localparam logic AXIS_Y = 1'b1;

   // configuration register indexes
   localparam logic [CSR_A_W-1:0] CSR_DEAD_ZONE  = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_OUTER_ZONE = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_X_CODE     = 2'd2;
   localparam logic [CSR_A_W-1:0] CSR_Y_CODE     = 2'd3;

   // configuration reset values
   localparam logic [ZONE_W-1:0] DEAD_ZONE_RST  = 14'd4915;
   localparam logic [ZONE_W-1:0] OUTER_ZONE_RST = 14'd3277;
   localparam logic [CODE_W-1:0] X_CODE_RST     = 6'd0;
   localparam logic [CODE_W-1:0] Y_CODE_RST     = 6'd1;

   // stick position snapshot taken at a sync report
   typedef struct packed {
      logic signed [AXIS_W-1:0] y;
      logic signed [AXIS_W-1:0] x;
   } pair_type;

   // configuration seen by the back end
   typedef struct packed {
      logic [ZONE_W-1:0] dead_zone;
      logic [ZONE_W-1:0] outer_zone;
      logic [CODE_W-1:0] x_code;
      logic [CODE_W-1:0] y_code;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rsd_front.sv =====
// ---------------------------------------------------------------------------
// rsd_front: input word classifier
// Stores axis samples and pushes a position snapshot for each sync report.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsd_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [rsd_pkg::AXIS_W-1:0]     req_tdata,  // axis_value
   input  wire logic [1:0]                     req_tuser,  // command, axis_index
   input  wire logic                           queue_full,
   output logic                                push,
   output rsd_pkg::pair_type                   push_pair
);

   logic signed [rsd_pkg::AXIS_W-1:0] x_ff, x_in;
   logic signed [rsd_pkg::AXIS_W-1:0] y_ff, y_in;
   logic                              accept;
   logic                              cmd;
   logic                              axis;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = req_tuser[0];
   assign axis       = req_tuser[1];

   // sync report queues the current position
   assign push        = accept && (cmd == rsd_pkg::CMD_SYNC);
   assign push_pair.x = x_ff;
   assign push_pair.y = y_ff;

   // axis sample updates the stored position
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (accept && (cmd == rsd_pkg::CMD_SAMPLE)) begin
         if (axis == rsd_pkg::AXIS_X) begin
            x_in = req_tdata;
         end else begin
            y_in = req_tdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rsd_queue.sv =====
// ---------------------------------------------------------------------------
// rsd_queue: short job queue
// Holds position snapshots between the front end and the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsd_queue #(
   parameter int DEPTH = rsd_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire rsd_pkg::pair_type push_pair,
   output logic                   full,
   output logic                   not_empty,
   input  wire logic              pop,
   output rsd_pkg::pair_type      head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   rsd_pkg::pair_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == DEPTH_CNT);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_pair;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rsd_back.sv =====
// ---------------------------------------------------------------------------
// rsd_back: deadzone compute engine
// Iterative square root and two restoring dividers produce the conditioned
// pair, then an output register sends X and Y when the pair has changed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsd_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rsd_pkg::cfg_type              cfg,
   input  wire logic                          job_valid,
   input  wire rsd_pkg::pair_type             job,
   output logic                               job_pop,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [23:0]                        rsp_tdata,  // out_value, zero fill
   output logic [rsd_pkg::CODE_W-1:0]         rsp_tuser,  // out_code
   output logic                               rsp_tlast
);

   localparam int OW = rsd_pkg::OUT_W;

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SQR   = 4'd1;
   localparam logic [3:0] ST_SUM   = 4'd2;
   localparam logic [3:0] ST_ROOT  = 4'd3;
   localparam logic [3:0] ST_PREP  = 4'd4;
   localparam logic [3:0] ST_MUL   = 4'd5;
   localparam logic [3:0] ST_DINIT = 4'd6;
   localparam logic [3:0] ST_DIV   = 4'd7;
   localparam logic [3:0] ST_CHK   = 4'd8;
   localparam logic [3:0] ST_SENDX = 4'd9;
   localparam logic [3:0] ST_SENDY = 4'd10;

   localparam logic [4:0]    ROOT_LAST = 5'd23;
   localparam logic [4:0]    DIV_LAST  = 5'd16;
   localparam logic [OW-1:0] FS_VAL    = OW'(rsd_pkg::FULL_SCALE);

   logic [3:0]              state_ff, state_in;
   logic signed [15:0]      x_ff, x_in, y_ff, y_in;
   logic [30:0]             sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [47:0]             rad_ff, rad_in;
   logic [25:0]             rem_ff, rem_in;
   logic [23:0]             root_ff, root_in;
   logic [4:0]              cnt_ff, cnt_in;
   logic [15:0]             rise_ff, rise_in, span_ff, span_in;
   logic [15:0]             ax_ff, ax_in, ay_ff, ay_in;
   logic                    zero_ff, zero_in;
   logic [31:0]             px_ff, px_in, py_ff, py_in;
   logic [39:0]             den_ff, den_in;
   logic [54:0]             remx_ff, remx_in, remy_ff, remy_in;
   logic [55:0]             dsh_ff, dsh_in;
   logic [OW-1:0]           qx_ff, qx_in, qy_ff, qy_in;
   logic                    ovx_ff, ovx_in, ovy_ff, ovy_in;
   logic [OW-1:0]           lastx_ff, lastx_in, lasty_ff, lasty_in;
   logic                    ovalid_ff, ovalid_in;
   logic [OW-1:0]           odata_ff, odata_in;
   logic [rsd_pkg::CODE_W-1:0] ocode_ff, ocode_in;
   logic                    olast_ff, olast_in;

   logic [27:0]             rem_sh;
   logic [27:0]             trial;
   logic                    root_ge;
   logic [15:0]             r_val;
   logic [15:0]             lim;
   logic [15:0]             rcap;
   logic [15:0]             dz16;
   logic                    gex, gey;
   logic [OW-1:0]           qxc, qyc;
   logic [OW-1:0]           ox, oy;
   logic                    out_take;

   assign job_pop    = (state_ff == ST_IDLE) && job_valid;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {7'd0, odata_ff};
   assign rsp_tuser  = ocode_ff;
   assign rsp_tlast  = olast_ff;
   assign out_take   = ovalid_ff && rsp_tready;

   // square root digit step: two radicand bits per cycle
   assign rem_sh  = {rem_ff, rad_ff[47:46]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign root_ge = (rem_sh >= trial);

   // radius cap and deadzone test
   assign r_val = root_ff[23:8];
   assign lim   = 16'(17'(rsd_pkg::FULL_SCALE) - {3'd0, cfg.outer_zone});
   assign rcap  = (r_val > lim) ? lim : r_val;
   assign dz16  = {2'd0, cfg.dead_zone};

   // restoring divide compare, one quotient bit per cycle
   assign gex = ({1'b0, remx_ff} >= dsh_ff);
   assign gey = ({1'b0, remy_ff} >= dsh_ff);

   // clamp, then restore sign
   assign qxc = (ovx_ff || (qx_ff > FS_VAL)) ? FS_VAL : qx_ff;
   assign qyc = (ovy_ff || (qy_ff > FS_VAL)) ? FS_VAL : qy_ff;
   assign ox  = zero_ff ? '0 : (x_ff[15] ? OW'(0) - qxc : qxc);
   assign oy  = zero_ff ? '0 : (y_ff[15] ? OW'(0) - qyc : qyc);

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      sqx_in    = sqx_ff;
      sqy_in    = sqy_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      cnt_in    = cnt_ff;
      rise_in   = rise_ff;
      span_in   = span_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      zero_in   = zero_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      den_in    = den_ff;
      remx_in   = remx_ff;
      remy_in   = remy_ff;
      dsh_in    = dsh_ff;
      qx_in     = qx_ff;
      qy_in     = qy_ff;
      ovx_in    = ovx_ff;
      ovy_in    = ovy_ff;
      lastx_in  = lastx_ff;
      lasty_in  = lasty_ff;
      ovalid_in = ovalid_ff;
      odata_in  = odata_ff;
      ocode_in  = ocode_ff;
      olast_in  = olast_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               x_in     = job.x;
               y_in     = job.y;
               state_in = ST_SQR;
            end
         end
         // squares of both axes
         ST_SQR: begin
            sqx_in   = 31'(32'(x_ff) * 32'(x_ff));
            sqy_in   = 31'(32'(y_ff) * 32'(y_ff));
            state_in = ST_SUM;
         end
         // radicand is s scaled by 2^16 for 8 fraction bits of magnitude
         ST_SUM: begin
            rad_in   = {32'({1'b0, sqx_ff} + {1'b0, sqy_ff}), 16'd0};
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rad_in = {rad_ff[45:0], 2'b00};
            if (root_ge) begin
               rem_in  = 26'(rem_sh - trial);
               root_in = {root_ff[22:0], 1'b1};
            end else begin
               rem_in  = 26'(rem_sh);
               root_in = {root_ff[22:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ROOT_LAST) begin
               state_in = ST_PREP;
            end
         end
         // rescale bounds and absolute axis values
         ST_PREP: begin
            zero_in  = (rcap <= dz16);
            rise_in  = rcap - dz16;
            span_in  = lim - dz16;
            ax_in    = x_ff[15] ? 16'(16'd0 - x_ff) : x_ff;
            ay_in    = y_ff[15] ? 16'(16'd0 - y_ff) : y_ff;
            state_in = (rcap <= dz16) ? ST_CHK : ST_MUL;
         end
         ST_MUL: begin
            px_in    = rise_ff * ax_ff;
            py_in    = rise_ff * ay_ff;
            den_in   = span_ff * root_ff;
            state_in = ST_DINIT;
         end
         // quotient at or above 2^17 saturates straight away
         ST_DINIT: begin
            remx_in  = {px_ff, 23'd0};
            remy_in  = {py_ff, 23'd0};
            ovx_in   = ({2'd0, px_ff, 6'd0} >= den_ff);
            ovy_in   = ({2'd0, py_ff, 6'd0} >= den_ff);
            dsh_in   = {den_ff, 16'd0};
            qx_in    = '0;
            qy_in    = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (gex) begin
               remx_in = remx_ff - dsh_ff[54:0];
            end
            if (gey) begin
               remy_in = remy_ff - dsh_ff[54:0];
            end
            qx_in  = {qx_ff[OW-2:0], gex};
            qy_in  = {qy_ff[OW-2:0], gey};
            dsh_in = {1'b0, dsh_ff[55:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_CHK;
            end
         end
         // send only a changed pair
         ST_CHK: begin
            if ((ox != lastx_ff) || (oy != lasty_ff)) begin
               lastx_in  = ox;
               lasty_in  = oy;
               ovalid_in = 1'b1;
               odata_in  = ox;
               ocode_in  = cfg.x_code;
               olast_in  = 1'b0;
               state_in  = ST_SENDX;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SENDX: begin
            if (out_take) begin
               odata_in = lasty_ff;
               ocode_in = cfg.y_code;
               olast_in = 1'b1;
               state_in = ST_SENDY;
            end
         end
         ST_SENDY: begin
            if (out_take) begin
               ovalid_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ovalid_ff <= 1'b0;
         lastx_ff  <= '0;
         lasty_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
         lastx_ff  <= lastx_in;
         lasty_ff  <= lasty_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      cnt_ff   <= cnt_in;
      rise_ff  <= rise_in;
      span_ff  <= span_in;
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      zero_ff  <= zero_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      den_ff   <= den_in;
      remx_ff  <= remx_in;
      remy_ff  <= remy_in;
      dsh_ff   <= dsh_in;
      qx_ff    <= qx_in;
      qy_ff    <= qy_in;
      ovx_ff   <= ovx_in;
      ovy_ff   <= ovy_in;
      odata_ff <= odata_in;
      ocode_ff <= ocode_in;
      olast_ff <= olast_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/radial_stick_deadzone.sv =====
// ---------------------------------------------------------------------------
// radial_stick_deadzone: scaled radial deadzone for a two-axis stick
// Input words carry axis samples or sync reports; each sync report yields
// a conditioned X/Y pair when the pair differs from the one sent before.
//
// req channel: tuser[0] is the command (axis sample or sync report),
// tuser[1] picks X or Y, tdata is the signed raw position.
// rsp channel: X word, then Y word with tlast high; tuser is the configured code.
// csr port: one write per cycle at csr_we, index 0 dead zone, 1 outer zone, 2 X
// code, 3 Y code. The user writes it only while the block is idle; not enforced.
// Sequence: with the engine free, a sync report passes the job queue, then the
// squares, the 24-step square root, the rescale, the products and the 17-step
// divide before the X word is offered; inside the deadzone the products and the
// divide are skipped. The engine takes the next sync report once the Y word is
// taken, or once the check finds an unchanged pair. Axis samples are taken
// at once while the job queue has room. A stalled receiver holds the result word
// and the engine; the front keeps taking words until the queue fills.
// Reset: registers return to their defaults, stored positions and the last
// pair sent are zero, the queue is empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module radial_stick_deadzone #(
   parameter int QUEUE_DEPTH = rsd_pkg::QUEUE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [15:0]                   req_tdata,  // axis_value
   input  wire logic [1:0]                    req_tuser,  // command, axis_index
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [23:0]                        rsp_tdata,  // out_value, zero fill
   output logic [5:0]                         rsp_tuser,  // out_code
   output logic                               rsp_tlast,
   input  wire logic                          csr_we,
   input  wire logic [rsd_pkg::CSR_A_W-1:0]   csr_addr,
   input  wire logic [rsd_pkg::ZONE_W-1:0]    csr_wdata
);

   rsd_pkg::cfg_type   cfg_ff, cfg_in;
   rsd_pkg::pair_type  push_pair;
   rsd_pkg::pair_type  head;
   logic               push;
   logic               queue_full;
   logic               not_empty;
   logic               job_pop;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            rsd_pkg::CSR_DEAD_ZONE:  cfg_in.dead_zone  = csr_wdata;
            rsd_pkg::CSR_OUTER_ZONE: cfg_in.outer_zone = csr_wdata;
            rsd_pkg::CSR_X_CODE:     cfg_in.x_code     = csr_wdata[rsd_pkg::CODE_W-1:0];
            rsd_pkg::CSR_Y_CODE:     cfg_in.y_code     = csr_wdata[rsd_pkg::CODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_zone  <= rsd_pkg::DEAD_ZONE_RST;
         cfg_ff.outer_zone <= rsd_pkg::OUTER_ZONE_RST;
         cfg_ff.x_code     <= rsd_pkg::X_CODE_RST;
         cfg_ff.y_code     <= rsd_pkg::Y_CODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: sample store and sync classification
   rsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_pair  (push_pair)
   );

   // job queue
   rsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_pair (push_pair),
      .full      (queue_full),
      .not_empty (not_empty),
      .pop       (job_pop),
      .head      (head)
   );

   // compute engine and result register
   rsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .job_valid  (not_empty),
      .job        (head),
      .job_pop    (job_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
